/* rtl/gfwd_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types for the gain fold/wrap distortion core
package gfwd_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int GAIN_INT_BITS_DEF = 5;
    localparam int CFG_INDEX_BITS    = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GAIN_MIN,
        CFG_GAIN_MAX,
        CFG_WRAP_START,
        CFG_WET
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_GAIN,
        ST_MUL_Y,
        ST_RANGE,
        ST_MUL_WET,
        ST_MUL_DRY,
        ST_MIX
    } state_t;

endpackage

/* rtl/gain_fold_wrap_distortion_core.sv */
`timescale 1ns / 1ps
// gain fold/wrap distortion core: sequencer around one shared multiplier
//
// Input channel s_*: one word per audio sample, carrying sample_in and
// modulation in s_tdata and the mode toggle flag in s_tuser. Output channel
// m_*: one word per input word, the mixed sample in m_tdata.
// The configuration port writes gain_min, gain_max, wrap_mode_at_start and
// wet_fraction by index; writing wrap_mode_at_start also sets the current mode.
//
// Each accepted word steps through MUL_GAIN, GAIN, MUL_Y, RANGE, MUL_WET,
// MUL_DRY and MIX before m_tvalid rises. The single multiplier is used four
// times per word (gain slope, sample times gain, wet and dry mix terms),
// with a gain add and a range step between them and a final sum step after.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new word is taken while the
// previous result still waits; if the receiver stalls, the next result
// holds in the last step until the output register frees up.
// Reset clears the sequencer and output valid, loads gain 1.0 / 2.0, fold
// mode and a wet fraction of zero.
module gain_fold_wrap_distortion_core #(
    parameter int SAMPLE_BITS   = gfwd_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_INT_BITS = gfwd_pkg::GAIN_INT_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample_in, modulation
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // mode_toggle
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [gfwd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [SAMPLE_BITS-1:0]                 cfg_data
);

    localparam int S      = SAMPLE_BITS;
    localparam int FRAC_S = S - 1;
    localparam int FRAC_G = S - GAIN_INT_BITS;
    localparam int K      = FRAC_S + FRAC_G;
    localparam int MW     = S + 1;
    localparam int PW     = 2 * MW;
    localparam int YW     = 2 * S + 1;
    localparam int OUT_W  = ((S + 7) / 8) * 8;

    localparam logic [S-1:0]           GAIN_MIN_RST = S'(1) << FRAC_G;
    localparam logic [S-1:0]           GAIN_MAX_RST = S'(1) << (FRAC_G + 1);
    localparam logic signed [MW-1:0]   WET_ONE      = MW'(1) << FRAC_S;
    localparam logic signed [YW-1:0]   ONE_Y        = YW'(1) << K;
    localparam logic signed [YW-1:0]   MASK_1       = ONE_Y - YW'(1);
    localparam logic signed [YW-1:0]   MASK_4       = (ONE_Y <<< 2) - YW'(1);
    localparam logic signed [PW:0]     MIX_HI       = ((PW+1)'(1) << FRAC_S) - (PW+1)'(1);
    localparam logic signed [PW:0]     MIX_LO       = -((PW+1)'(1) << FRAC_S);

    gfwd_pkg::state_t state_reg, state_next;

    // configuration and mode
    logic signed [S-1:0] gain_min_reg, gain_min_next;
    logic signed [S-1:0] gain_max_reg, gain_max_next;
    logic [S-1:0]        wet_reg, wet_next;
    logic                wrap_mode_reg, wrap_mode_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic signed [S-1:0]  samp_reg, samp_next;
    logic [S-1:0]         am_reg, am_next;
    logic signed [MW-1:0] diff_reg, diff_next;
    logic signed [MW-1:0] wet_eff_reg, wet_eff_next;
    logic signed [MW-1:0] dry_w_reg, dry_w_next;
    logic signed [MW-1:0] gain_reg, gain_next;
    logic signed [MW-1:0] r_reg, r_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic [S-1:0]         out_reg, out_next;

    logic                 in_accept;
    logic                 mix_go;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    logic signed [S-1:0]  in_samp, in_mod;
    logic signed [MW-1:0] in_wet;
    logic signed [PW-1:0] gain_q;
    logic signed [YW-1:0] y, rng_hi, rng_lo, fold_m, fold_v, rng_v, rng_sh;
    logic signed [PW:0]   mix_sum, mix_sh;

    assign in_accept = s_tvalid && s_tready;
    assign mix_go    = !out_valid_reg || m_tready;
    assign in_samp   = s_tdata[S-1:0];
    assign in_mod    = s_tdata[2*S-1:S];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gfwd_pkg::ST_IDLE:     if (in_accept) state_next = gfwd_pkg::ST_MUL_GAIN;
            gfwd_pkg::ST_MUL_GAIN: state_next = gfwd_pkg::ST_GAIN;
            gfwd_pkg::ST_GAIN:     state_next = gfwd_pkg::ST_MUL_Y;
            gfwd_pkg::ST_MUL_Y:    state_next = gfwd_pkg::ST_RANGE;
            gfwd_pkg::ST_RANGE:    state_next = gfwd_pkg::ST_MUL_WET;
            gfwd_pkg::ST_MUL_WET:  state_next = gfwd_pkg::ST_MUL_DRY;
            gfwd_pkg::ST_MUL_DRY:  state_next = gfwd_pkg::ST_MIX;
            gfwd_pkg::ST_MIX:      if (mix_go) state_next = gfwd_pkg::ST_IDLE;
            default:               state_next = gfwd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operand select
    always_comb
    begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            gfwd_pkg::ST_IDLE:     s_tready = 1'b1;
            gfwd_pkg::ST_MUL_GAIN:
            begin
                mul_a = diff_reg;
                mul_b = {1'b0, am_reg};
            end
            gfwd_pkg::ST_MUL_Y:
            begin
                mul_a = {samp_reg[S-1], samp_reg};
                mul_b = gain_reg;
            end
            gfwd_pkg::ST_MUL_WET:
            begin
                mul_a = wet_eff_reg;
                mul_b = r_reg;
            end
            gfwd_pkg::ST_MUL_DRY:
            begin
                mul_a = dry_w_reg;
                mul_b = {samp_reg[S-1], samp_reg};
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- datapath ----------------
    // gain slope is floored by 2^S: half the difference times |mod| in Q1.15
    assign gain_q = prod_reg >>> S;

    // range step on the exact product
    assign y      = prod_reg[YW-1:0];
    assign rng_hi = ((y - ONE_Y - YW'(1)) & MASK_1) + YW'(1);
    assign rng_lo = -(((~y - ONE_Y) & MASK_1) + YW'(1));
    assign fold_m = (y + ONE_Y) & MASK_4;
    assign fold_v = (fold_m <= (ONE_Y <<< 1)) ? (fold_m - ONE_Y)
                                              : ((ONE_Y <<< 1) + ONE_Y - fold_m);

    always_comb
    begin
        if (y <= ONE_Y && y >= -ONE_Y)
            rng_v = y;
        else if (!wrap_mode_reg)
            rng_v = fold_v;
        else if (y > ONE_Y)
            rng_v = rng_hi;
        else
            rng_v = rng_lo;
    end

    assign rng_sh  = rng_v >>> FRAC_G;
    assign mix_sum = {acc_reg[PW-1], acc_reg} + {prod_reg[PW-1], prod_reg};
    assign mix_sh  = mix_sum >>> FRAC_S;
    assign in_wet  = {1'b0, wet_reg};

    always_comb
    begin
        gain_min_next  = gain_min_reg;
        gain_max_next  = gain_max_reg;
        wet_next       = wet_reg;
        wrap_mode_next = wrap_mode_reg;
        out_valid_next = out_valid_reg && !m_tready;

        samp_next    = samp_reg;
        am_next      = am_reg;
        diff_next    = diff_reg;
        wet_eff_next = wet_eff_reg;
        dry_w_next   = dry_w_reg;
        gain_next    = gain_reg;
        r_next       = r_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;

        if (cfg_wr_en)
        begin
            case (gfwd_pkg::cfg_index_t'(cfg_index))
                gfwd_pkg::CFG_GAIN_MIN:   gain_min_next  = cfg_data;
                gfwd_pkg::CFG_GAIN_MAX:   gain_max_next  = cfg_data;
                gfwd_pkg::CFG_WRAP_START: wrap_mode_next = cfg_data[0];
                gfwd_pkg::CFG_WET:        wet_next       = cfg_data;
                default:                  wet_next       = wet_reg;
            endcase
        end

        case (state_reg)
            gfwd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    wrap_mode_next = wrap_mode_reg ^ s_tuser;
                    samp_next      = in_samp;
                    // |-full scale| wraps to the unsigned value of 1.0
                    am_next        = in_mod[S-1] ? (~in_mod + S'(1)) : in_mod;
                    diff_next      = {gain_max_reg[S-1], gain_max_reg}
                                   - {gain_min_reg[S-1], gain_min_reg};
                    wet_eff_next   = (in_wet > WET_ONE) ? WET_ONE : in_wet;
                    dry_w_next     = WET_ONE - ((in_wet > WET_ONE) ? WET_ONE : in_wet);
                end
            end
            gfwd_pkg::ST_MUL_GAIN,
            gfwd_pkg::ST_MUL_Y,
            gfwd_pkg::ST_MUL_WET:
            begin
                prod_next = mul_p;
            end
            gfwd_pkg::ST_GAIN:
            begin
                gain_next = {gain_min_reg[S-1], gain_min_reg} + gain_q[MW-1:0];
            end
            gfwd_pkg::ST_RANGE:
            begin
                r_next = rng_sh[MW-1:0];
            end
            gfwd_pkg::ST_MUL_DRY:
            begin
                acc_next  = prod_reg;
                prod_next = mul_p;
            end
            gfwd_pkg::ST_MIX:
            begin
                if (mix_go)
                begin
                    out_valid_next = 1'b1;
                    if (mix_sh > MIX_HI)
                        out_next = MIX_HI[S-1:0];
                    else if (mix_sh < MIX_LO)
                        out_next = MIX_LO[S-1:0];
                    else
                        out_next = mix_sh[S-1:0];
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfwd_pkg::ST_IDLE;
            gain_min_reg  <= GAIN_MIN_RST;
            gain_max_reg  <= GAIN_MAX_RST;
            wet_reg       <= '0;
            wrap_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_min_reg  <= gain_min_next;
            gain_max_reg  <= gain_max_next;
            wet_reg       <= wet_next;
            wrap_mode_reg <= wrap_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg    <= samp_next;
        am_reg      <= am_next;
        diff_reg    <= diff_next;
        wet_eff_reg <= wet_eff_next;
        dry_w_reg   <= dry_w_next;
        gain_reg    <= gain_next;
        r_reg       <= r_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_reg);

endmodule

/* rtl/gfwd_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the gain fold/wrap distortion core, with its bind
module gfwd_checker #(
    parameter int SAMPLE_BITS = gfwd_pkg::SAMPLE_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata
);

    // a word occupies the sequencer: s_tready stays low after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input taken again too soon after a word");

    // a new result only comes out of a busy sequencer
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a word in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed or dropped");

endmodule

bind gain_fold_wrap_distortion_core gfwd_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_gfwd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
